// File: rtl/core/csoc_pkg.sv
// Shared types and constants for the compacted state offset calculator.
// No dependencies; used by csoc_residue, csoc_table, csoc_walk and the top level.
`default_nettype none

package csoc_pkg;

    // Field widths fixed by the item formats
    localparam int COMP_W    = 6;
    localparam int SIZE_W    = 16;
    localparam int MASK_W    = 64;
    localparam int ACT_W     = 7;
    localparam int MAX_W     = 16;
    localparam int OUT_OFF_W = 17;
    localparam int IN_DATA_W = 88;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_W     = 16;

    // Running offset: base up to 8 KiB plus 62 components of up to 64 KiB each,
    // plus alignment padding, stays below 2**23
    localparam int OFF_W = 23;
    // Residue field wide enough for the largest supported alignment (4096)
    localparam int RES_W = 12;

    localparam logic [OUT_OFF_W-1:0] OFF_SAT = {OUT_OFF_W{1'b1}};

    // First component index visited by a walk
    localparam int FIRST_WALKED = 2;

    // Parameter defaults
    localparam int DEF_NUM_COMPONENTS    = 64;
    localparam int DEF_LEGACY_AREA_BYTES = 512;
    localparam int DEF_HEADER_BYTES      = 64;
    localparam int DEF_ALIGN_BYTES       = 64;

    // Register reset values
    localparam logic [ACT_W-1:0] RST_ACTIVE   = 7'd64;
    localparam logic [MAX_W-1:0] RST_MAX_AREA = 16'hFFFF;

    // Request kinds carried in tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [0:0] {
        CFG_ACTIVE   = 1'b0,
        CFG_MAX_AREA = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_TOTAL = 3'b100
    } walk_state_t;

    // Table write from the load pipeline
    typedef struct packed {
        logic              valid;
        logic [COMP_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic              align;
        logic [RES_W-1:0]  res;
    } tbl_wr_t;

    // One result record
    typedef struct packed {
        logic                 last;
        logic                 is_total;
        logic                 overflow;
        logic [OUT_OFF_W-1:0] offset;
        logic [COMP_W-1:0]    comp;
    } out_rec_t;

endpackage

`default_nettype wire

// File: rtl/core/csoc_residue.sv
// Load pipeline: computes a component size modulo the alignment and
// issues the table write. Depends on csoc_pkg.
`default_nettype none

module csoc_residue #(
    parameter int ALIGN_BYTES = csoc_pkg::DEF_ALIGN_BYTES
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire [csoc_pkg::COMP_W-1:0]   comp,
    input  wire [csoc_pkg::SIZE_W-1:0]   size,
    input  wire                          align,
    output logic                         busy,
    output csoc_pkg::tbl_wr_t            wr
);

    localparam int SW      = csoc_pkg::SIZE_W;
    localparam int ALIGN_W = $clog2(ALIGN_BYTES + 1);
    // floor(2**16 / A): quotient estimate is exact or one short
    localparam logic [SW:0]        RECIP   = (SW+1)'((2 ** SW) / ALIGN_BYTES);
    localparam logic [ALIGN_W-1:0] ALIGN_C = ALIGN_W'(ALIGN_BYTES);

    logic                           v1_reg, v2_reg, v3_reg;
    logic [csoc_pkg::COMP_W-1:0]    comp_reg;
    logic [SW-1:0]                  size_reg;
    logic                           align_reg;
    logic [SW:0]                    q_reg;
    logic [SW:0]                    qa_reg;

    logic [2*SW:0]                  prod;
    logic [SW+ALIGN_W:0]            qa_full;
    logic [SW:0]                    diff;
    logic [SW:0]                    res;

    assign prod    = (2*SW+1)'(size_reg) * (2*SW+1)'(RECIP);
    assign qa_full = (SW+ALIGN_W+1)'(q_reg) * (SW+ALIGN_W+1)'(ALIGN_C);
    assign diff    = {1'b0, size_reg} - qa_reg;
    // one correction step covers the short quotient estimate
    assign res     = (diff >= (SW+1)'(ALIGN_C)) ? diff - (SW+1)'(ALIGN_C) : diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            comp_reg  <= comp;
            size_reg  <= size;
            align_reg <= align;
        end
        q_reg  <= prod[2*SW:SW];
        qa_reg <= qa_full[SW:0];
    end

    assign busy     = v1_reg | v2_reg | v3_reg;
    assign wr.valid = v3_reg;
    assign wr.addr  = comp_reg;
    assign wr.size  = size_reg;
    assign wr.align = align_reg;
    assign wr.res   = csoc_pkg::RES_W'(res);

endmodule

`default_nettype wire

// File: rtl/core/csoc_table.sv
// Component table: size, alignment flag and size residue in one synchronous
// memory, plus per-entry valid bits for the flag reset. Depends on csoc_pkg.
`default_nettype none

module csoc_table #(
    parameter int NUM_COMPONENTS = csoc_pkg::DEF_NUM_COMPONENTS,
    parameter int ALIGN_BYTES    = csoc_pkg::DEF_ALIGN_BYTES
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire csoc_pkg::tbl_wr_t          wr,
    input  wire [$clog2(NUM_COMPONENTS)-1:0] rd_addr,
    output logic [csoc_pkg::SIZE_W-1:0]     rd_size,
    output logic                            rd_align,
    output logic [((ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1)-1:0] rd_res
);

    localparam int IDX_W = $clog2(NUM_COMPONENTS);
    localparam int REM_W = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
    localparam int ENT_W = csoc_pkg::SIZE_W + 1 + REM_W;
    localparam logic [csoc_pkg::COMP_W:0] NUM_C = (csoc_pkg::COMP_W+1)'(NUM_COMPONENTS);

    logic [ENT_W-1:0]          mem [NUM_COMPONENTS];
    logic [NUM_COMPONENTS-1:0] valid_reg;
    logic [ENT_W-1:0]          rd_q_reg;
    logic                      rd_v_reg;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_idx;

    // entries beyond the walked range are never read: drop those writes
    assign wr_en  = wr.valid && ({1'b0, wr.addr} < NUM_C);
    assign wr_idx = IDX_W'(wr.addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= {wr.size, wr.align, wr.res[REM_W-1:0]};
        end
        rd_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_v_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            rd_v_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_size  = rd_q_reg[ENT_W-1 -: csoc_pkg::SIZE_W];
    assign rd_align = rd_v_reg & rd_q_reg[REM_W];
    assign rd_res   = rd_q_reg[REM_W-1:0];

endmodule

`default_nettype wire

// File: rtl/core/csoc_walk.sv
// Query sequencer: one table index per cycle unless stalled; keeps the running
// offset and its residue, and drives the result register. Depends on csoc_pkg.
`default_nettype none

module csoc_walk #(
    parameter int NUM_COMPONENTS    = csoc_pkg::DEF_NUM_COMPONENTS,
    parameter int LEGACY_AREA_BYTES = csoc_pkg::DEF_LEGACY_AREA_BYTES,
    parameter int HEADER_BYTES      = csoc_pkg::DEF_HEADER_BYTES,
    parameter int ALIGN_BYTES       = csoc_pkg::DEF_ALIGN_BYTES
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    input  wire [NUM_COMPONENTS-1:0]         mask,
    input  wire [csoc_pkg::ACT_W-1:0]        limit,
    input  wire [csoc_pkg::MAX_W-1:0]        max_area,
    output logic                             idle,
    output logic [$clog2(NUM_COMPONENTS)-1:0] rd_addr,
    input  wire [csoc_pkg::SIZE_W-1:0]       rd_size,
    input  wire                              rd_align,
    input  wire [((ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1)-1:0] rd_res,
    output logic                             out_valid,
    input  wire                              out_ready,
    output csoc_pkg::out_rec_t               out_rec
);

    localparam int IDX_W = $clog2(NUM_COMPONENTS);
    localparam int REM_W = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
    localparam int OW    = csoc_pkg::OFF_W;
    localparam int AW    = csoc_pkg::ACT_W;
    localparam int BASE  = LEGACY_AREA_BYTES + HEADER_BYTES;
    localparam logic [OW-1:0]    BASE_OFF  = OW'(BASE);
    localparam logic [REM_W-1:0] BASE_REM  = REM_W'(BASE % ALIGN_BYTES);
    localparam logic [REM_W:0]   ALIGN_C   = (REM_W+1)'(ALIGN_BYTES);
    localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(csoc_pkg::FIRST_WALKED);
    localparam logic [AW-1:0]    FIRST_C   = AW'(csoc_pkg::FIRST_WALKED);

    csoc_pkg::walk_state_t state_reg, state_next;

    logic [NUM_COMPONENTS-1:0] mask_reg;
    logic [AW-1:0]             lim_m1_reg;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [OW-1:0]             off_reg, off_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [csoc_pkg::MAX_W-1:0] max_reg;
    logic                      out_valid_reg, out_valid_next;
    csoc_pkg::out_rec_t        out_rec_reg, out_rec_next;

    logic                      load_ok;
    logic                      present;
    logic                      idx_last;
    logic                      pad;
    logic [REM_W:0]            pad_amt;
    logic [OW-1:0]             off_al;
    logic [REM_W-1:0]          rem_al;
    logic [REM_W:0]            rem_sum;
    logic [OW-1:0]             off_sum;
    logic                      emit;
    logic                      stall;

    function automatic logic [csoc_pkg::OUT_OFF_W-1:0] sat(input logic [OW-1:0] v);
        return (v > OW'(csoc_pkg::OFF_SAT)) ? csoc_pkg::OFF_SAT
                                            : v[csoc_pkg::OUT_OFF_W-1:0];
    endfunction

    assign load_ok  = !out_valid_reg || out_ready;
    assign present  = mask_reg[idx_reg];
    assign idx_last = (AW'(idx_reg) == lim_m1_reg);

    // round up: residue tracks off mod A, so padding is A minus residue
    assign pad     = rd_align && (rem_reg != '0);
    assign pad_amt = ALIGN_C - {1'b0, rem_reg};
    assign off_al  = pad ? off_reg + OW'(pad_amt) : off_reg;
    assign rem_al  = pad ? '0 : rem_reg;
    assign rem_sum = {1'b0, rem_al} + {1'b0, rd_res};
    assign off_sum = off_al + OW'(rd_size);

    assign emit  = ((state_reg == csoc_pkg::ST_WALK) && present)
                 || (state_reg == csoc_pkg::ST_TOTAL);
    assign stall = emit && !load_ok;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        off_next       = off_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_rec_next   = out_rec_reg;
        rd_addr        = idx_reg;

        case (state_reg)
            csoc_pkg::ST_IDLE:
            begin
                rd_addr = FIRST_IDX;
                if (start)
                begin
                    idx_next = FIRST_IDX;
                    off_next = BASE_OFF;
                    rem_next = BASE_REM;
                    state_next = (limit > FIRST_C) ? csoc_pkg::ST_WALK
                                                   : csoc_pkg::ST_TOTAL;
                end
            end
            csoc_pkg::ST_WALK:
            begin
                if (!stall)
                begin
                    if (present)
                    begin
                        out_valid_next        = 1'b1;
                        out_rec_next.comp     = csoc_pkg::COMP_W'(idx_reg);
                        out_rec_next.offset   = sat(off_al);
                        out_rec_next.overflow = 1'b0;
                        out_rec_next.is_total = 1'b0;
                        out_rec_next.last     = 1'b0;
                        off_next = off_sum;
                        rem_next = (rem_sum >= ALIGN_C) ? REM_W'(rem_sum - ALIGN_C)
                                                        : REM_W'(rem_sum);
                    end
                    if (idx_last)
                    begin
                        state_next = csoc_pkg::ST_TOTAL;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                    end
                end
            end
            csoc_pkg::ST_TOTAL:
            begin
                if (load_ok)
                begin
                    out_valid_next        = 1'b1;
                    out_rec_next.comp     = '0;
                    out_rec_next.offset   = sat(off_reg);
                    out_rec_next.overflow = off_reg > OW'(max_reg);
                    out_rec_next.is_total = 1'b1;
                    out_rec_next.last     = 1'b1;
                    state_next = csoc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = csoc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csoc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && (state_reg == csoc_pkg::ST_IDLE))
        begin
            mask_reg   <= mask;
            lim_m1_reg <= limit - 1'b1;
            max_reg    <= max_area;
        end
        idx_reg     <= idx_next;
        off_reg     <= off_next;
        rem_reg     <= rem_next;
        out_rec_reg <= out_rec_next;
    end

    assign idle      = (state_reg == csoc_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_rec   = out_rec_reg;

endmodule

`default_nettype wire

// File: rtl/core/compacted_state_offset_calc.sv
// Top level of the compacted state offset calculator: stream ports,
// configuration registers and the table, load and walk units. Depends on
// csoc_pkg, csoc_residue, csoc_table and csoc_walk.
//
// A load request (tuser = 0) writes one component entry: size and 64-byte
// alignment flag. It passes through the two-multiply pipeline that reduces
// the size modulo ALIGN_BYTES before the entry is written. A query request
// (tuser = 1) walks components 2 .. N-1, where N is active_components
// saturated to NUM_COMPONENTS, reading one table entry per cycle from the
// component memory; the walk stalls while the result register stays full
// and a present component or the total waits to be reported. Each present
// component gives one result with its aligned offset; a final result
// (tuser = 1, tlast = 1) gives the end offset and the overflow flag against
// max_area_size. Offsets above 131071 read as 131071. One request is in
// work at a time; s_axis_tready is low during it, while the last result of
// a query may still wait in the output register. Write configuration only
// while the block is idle.
`default_nettype none

module compacted_state_offset_calc #(
    parameter int NUM_COMPONENTS    = csoc_pkg::DEF_NUM_COMPONENTS,
    parameter int LEGACY_AREA_BYTES = csoc_pkg::DEF_LEGACY_AREA_BYTES,
    parameter int HEADER_BYTES      = csoc_pkg::DEF_HEADER_BYTES,
    parameter int ALIGN_BYTES       = csoc_pkg::DEF_ALIGN_BYTES
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // request stream
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: component[5:0], comp_size[21:6], align64[22], present_mask[86:23], pad
    input  wire [csoc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // tuser: opcode (0 load, 1 query)
    input  wire                                 s_axis_tuser,
    // result stream
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // tdata: out_component[5:0], offset[22:6], overflow[23]
    output logic [csoc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // tuser: is_total
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast,
    // configuration writes
    input  wire                                 cfg_we,
    input  wire [0:0]                           cfg_index,
    input  wire [csoc_pkg::CFG_W-1:0]           cfg_wdata
);

    localparam int IDX_W = $clog2(NUM_COMPONENTS);
    localparam int REM_W = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
    localparam int AW    = csoc_pkg::ACT_W;
    localparam logic [AW-1:0] NUM_C = AW'(NUM_COMPONENTS);

    // Configuration registers
    logic [AW-1:0]                active_reg;
    logic [csoc_pkg::MAX_W-1:0]   max_area_reg;

    // Request field breakout
    logic [csoc_pkg::COMP_W-1:0]  in_component;
    logic [csoc_pkg::SIZE_W-1:0]  in_comp_size;
    logic                         in_align64;
    logic [csoc_pkg::MASK_W-1:0]  in_present_mask;

    logic                         accept;
    logic                         load_start;
    logic                         query_start;
    logic                         ld_busy;
    logic                         walk_idle;
    logic [AW-1:0]                limit;

    csoc_pkg::tbl_wr_t            tbl_wr;
    logic [IDX_W-1:0]             rd_addr;
    logic [csoc_pkg::SIZE_W-1:0]  rd_size;
    logic                         rd_align;
    logic [REM_W-1:0]             rd_res;
    csoc_pkg::out_rec_t           out_rec;

    assign in_component    = s_axis_tdata[5:0];
    assign in_comp_size    = s_axis_tdata[21:6];
    assign in_align64      = s_axis_tdata[22];
    assign in_present_mask = s_axis_tdata[86:23];

    // One request at a time: a walk never reads the table while a load is
    // still writing it.
    assign s_axis_tready = walk_idle && !ld_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign load_start    = accept && (s_axis_tuser == csoc_pkg::OP_LOAD);
    assign query_start   = accept && (s_axis_tuser == csoc_pkg::OP_QUERY);

    // Saturate the component count to the table depth
    assign limit = (active_reg > NUM_C) ? NUM_C : active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= csoc_pkg::RST_ACTIVE;
            max_area_reg <= csoc_pkg::RST_MAX_AREA;
        end
        else if (cfg_we)
        begin
            case (csoc_pkg::cfg_idx_t'(cfg_index))
                csoc_pkg::CFG_ACTIVE:   active_reg   <= cfg_wdata[AW-1:0];
                csoc_pkg::CFG_MAX_AREA: max_area_reg <= cfg_wdata[csoc_pkg::MAX_W-1:0];
                default:                active_reg   <= active_reg;
            endcase
        end
    end

    csoc_residue #(
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_residue (
        .clk   (clk),
        .rst_n (rst_n),
        .start (load_start),
        .comp  (in_component),
        .size  (in_comp_size),
        .align (in_align64),
        .busy  (ld_busy),
        .wr    (tbl_wr)
    );

    csoc_table #(
        .NUM_COMPONENTS (NUM_COMPONENTS),
        .ALIGN_BYTES    (ALIGN_BYTES)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tbl_wr),
        .rd_addr  (rd_addr),
        .rd_size  (rd_size),
        .rd_align (rd_align),
        .rd_res   (rd_res)
    );

    csoc_walk #(
        .NUM_COMPONENTS    (NUM_COMPONENTS),
        .LEGACY_AREA_BYTES (LEGACY_AREA_BYTES),
        .HEADER_BYTES      (HEADER_BYTES),
        .ALIGN_BYTES       (ALIGN_BYTES)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (query_start),
        .mask      (in_present_mask[NUM_COMPONENTS-1:0]),
        .limit     (limit),
        .max_area  (max_area_reg),
        .idle      (walk_idle),
        .rd_addr   (rd_addr),
        .rd_size   (rd_size),
        .rd_align  (rd_align),
        .rd_res    (rd_res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rec   (out_rec)
    );

    assign m_axis_tdata = {out_rec.overflow, out_rec.offset, out_rec.comp};
    assign m_axis_tuser = out_rec.is_total;
    assign m_axis_tlast = out_rec.last;

endmodule

`default_nettype wire

// File: rtl/core/csoc_checker.sv
// Port-level checks for compacted_state_offset_calc, bound to the top level.
// No dependencies beyond the top level's ports.
`default_nettype none

module csoc_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata,
    input wire        m_axis_tuser,
    input wire        m_axis_tlast
);

    // the end-of-run record is the total record
    a_last_is_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
        else $error("tlast and total flag disagree");

    // the total record reports component zero
    a_total_comp: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[5:0] == 6'd0))
        else $error("total record with nonzero component");

    // component records never carry the overflow flag
    a_comp_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> !m_axis_tdata[23])
        else $error("overflow on a component record");

    // while a walk still owes its total, no new request is taken
    a_busy_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("request taken while a walk is in progress");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind compacted_state_offset_calc csoc_checker u_csoc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
